// File: rtl/rmss_pkg.sv
package rmss_pkg;

	// Field widths
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned PHASE_W   = 4;
	localparam int unsigned STEP_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 18;
	localparam int unsigned SHORT_W   = 16;
	localparam int unsigned LONG_W    = 18;
	localparam int unsigned RETRY_W   = 4;

	// Number of configuration commands in one sequence (1 to 3)
	localparam int unsigned NUM_STEPS = 3;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BYTE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CONFIG = 3'd2;
	localparam logic [REQ_W-1:0] REQ_START  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_END    = 3'd4;

	// Command answer codes
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACCEPT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BUSY   = 2'd2;

	// Link status codes
	localparam logic [STATUS_W-1:0] ST_READY       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFIGURING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STREAMING   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ERROR       = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONN_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd4;

	// Reset values of the configuration registers
	localparam logic [SHORT_W-1:0] BOOT_DELAY_RST  = 16'd500;
	localparam logic [SHORT_W-1:0] CMD_TIMEOUT_RST = 16'd500;
	localparam logic [LONG_W-1:0]  CONN_TIMEOUT_RST = 18'd60000;
	localparam logic [LONG_W-1:0]  IDLE_TIMEOUT_RST = 18'd60000;
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

	localparam logic [LONG_W-1:0]  ELAPSED_MAX = 18'h3FFFF;
	localparam logic [RETRY_W-1:0] RETRY_MAX   = 4'hF;

	// Reply words and single-byte requests
	localparam logic [23:0] ERR_WORD = 24'h455252;
	localparam logic [7:0]  ASK_BYTE = 8'h3F;
	localparam logic [7:0]  QUIT_BYTE = 8'h51;

	typedef struct packed {
		logic shift;
		logic clear;
	} scan_ctrl_t;

	typedef struct packed {
		logic quit;
		logic ask;
		logic err;
		logic ans;
	} scan_flags_t;

	// Expected answer of each configuration step
	function automatic logic [23:0] answer_word(input logic [STEP_W-1:0] step);
		logic [23:0] w;
		unique case (step)
			2'd0:    w = 24'h434D44;
			2'd1:    w = 24'h414F4B;
			default: w = 24'h454E44;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/rmss_req_if.sv
interface rmss_req_if;
	logic                          valid;
	logic                          ready;
	logic [rmss_pkg::REQ_W-1:0]    req_type;
	logic [rmss_pkg::BYTE_W-1:0]   rx_byte;
	logic                          rx_last;

	modport source (output valid, req_type, rx_byte, rx_last, input ready);
	modport sink (input valid, req_type, rx_byte, rx_last, output ready);
endinterface

// File: rtl/rmss_res_if.sv
interface rmss_res_if;
	logic                           valid;
	logic                           ready;
	logic [rmss_pkg::CMD_W-1:0]     cmd_result;
	logic [rmss_pkg::STATUS_W-1:0]  link_status;
	logic [rmss_pkg::PHASE_W-1:0]   phase_now;
	logic [rmss_pkg::STEP_W-1:0]    send_step;
	logic                           abort_rx;
	logic                           rearm_rx;

	modport source (output valid, cmd_result, link_status, phase_now, send_step,
		abort_rx, rearm_rx, input ready);
	modport sink (input valid, cmd_result, link_status, phase_now, send_step,
		abort_rx, rearm_rx, output ready);
endinterface

// File: rtl/rmss_cfg_if.sv
interface rmss_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rmss_pkg::CFG_IDX_W-1:0]  index;
	logic [rmss_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rmss_scan.sv
module rmss_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmss_pkg::scan_ctrl_t          ctrl,
	input  logic [rmss_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [rmss_pkg::STEP_W-1:0]   step,
	output rmss_pkg::scan_flags_t         flags
);
	import rmss_pkg::*;

	logic [15:0]  hist_q;
	logic [23:0]  word;
	logic         step_ok;
	scan_flags_t  flags_q;
	scan_flags_t  hits;

	// Match last three bytes to answer and error word, newest to ask/quit
	always_comb begin
		word      = {hist_q, rx_byte};
		step_ok   = ({1'b0, step} < 3'(NUM_STEPS));
		hits.ans  = step_ok && (word == answer_word(step));
		hits.err  = (word == ERR_WORD);
		hits.ask  = (rx_byte == ASK_BYTE);
		hits.quit = (rx_byte == QUIT_BYTE);
		flags     = flags_q | hits;
	end

	// Hold history and sticky flags; clear wins over shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			flags_q <= '0;
		end else if (ctrl.clear) begin
			hist_q  <= '0;
			flags_q <= '0;
		end else if (ctrl.shift) begin
			hist_q  <= word[15:0];
			flags_q <= flags;
		end
	end

endmodule

// File: rtl/radio_module_session_sequencer.sv
// Session sequencer for a serial radio module. Each transfer on req is a
// millisecond tick, one reply byte (rx_last closes a message) or a configure,
// start or end-stream command, and gives exactly one transfer on res with the
// command answer, the link status, the phase after the item and the strobes
// for the transmitter and receiver. Each item is handled as it is accepted: the
// state registers update at the accepting edge and the result sits in a
// single output register, so req takes one item per clock as long as res is
// drained, and stalls only while that register holds an untaken result.
// Configuration writes on cfg are always taken and should be made while the
// block is idle.
module radio_module_session_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	rmss_req_if.sink    req,
	rmss_res_if.source  res,
	rmss_cfg_if.sink    cfg
);
	import rmss_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE     = 4'd0,
		PH_CONFIG   = 4'd1,
		PH_CFG_WAIT = 4'd2,
		PH_START    = 4'd3,
		PH_WAIT_CMD = 4'd4,
		PH_STREAM   = 4'd5,
		PH_WAIT_ACK = 4'd6,
		PH_STOP     = 4'd7,
		PH_ERROR    = 4'd8
	} phase_t;

	// Configuration registers
	logic [SHORT_W-1:0]  boot_delay_q;
	logic [SHORT_W-1:0]  cmd_timeout_q;
	logic [LONG_W-1:0]   conn_timeout_q;
	logic [LONG_W-1:0]   idle_timeout_q;
	logic [RETRY_W-1:0]  retry_limit_q;

	// Sequencer state
	phase_t              phase_q, phase_d;
	logic [LONG_W-1:0]   elapsed_q, elapsed_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [RETRY_W-1:0]  retries_q, retries_d;
	logic [STATUS_W-1:0] status_q, status_d;

	// Result register
	logic                res_valid_q;
	logic [CMD_W-1:0]    cmd_q, cmd_d;
	logic [STEP_W-1:0]   send_q, send_d;
	logic                abort_q, abort_d;
	logic                rearm_q, rearm_d;
	logic [STATUS_W-1:0] status_res_q;
	phase_t              phase_res_q;

	logic                accept;
	logic [LONG_W-1:0]   elapsed_inc;
	logic [RETRY_W-1:0]  retries_inc;
	logic                fail_err;
	logic                step_ok;
	logic                listening;
	scan_ctrl_t          scan_ctrl;
	scan_flags_t         scan_flags;

	assign cfg.ready = 1'b1;
	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	rmss_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (scan_ctrl),
		.rx_byte (req.rx_byte),
		.step    (step_q),
		.flags   (scan_flags)
	);

	// Work out the next state and the result of the offered item
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		step_d    = step_q;
		retries_d = retries_q;
		status_d  = status_q;
		cmd_d     = CMD_NONE;
		send_d    = '0;
		abort_d   = 1'b0;
		rearm_d   = 1'b0;
		scan_ctrl = '0;

		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		retries_inc = (retries_q == RETRY_MAX) ? retries_q : retries_q + 1'b1;
		fail_err    = (retries_inc >= retry_limit_q);
		step_ok     = ({1'b0, step_q} < 3'(NUM_STEPS));
		listening   = (phase_q == PH_CFG_WAIT) || (phase_q == PH_WAIT_CMD) ||
			(phase_q == PH_WAIT_ACK);

		case (req.req_type)
			REQ_TICK: begin
				elapsed_d = elapsed_inc;
				case (phase_q)
					PH_CONFIG: begin
						if (elapsed_inc > {2'b00, boot_delay_q}) begin
							if (step_ok) begin
								send_d          = step_q + 1'b1;
								rearm_d         = 1'b1;
								scan_ctrl.clear = 1'b1;
								elapsed_d       = '0;
								phase_d         = PH_CFG_WAIT;
							end else begin
								status_d = ST_READY;
								phase_d  = PH_IDLE;
							end
						end
					end
					PH_CFG_WAIT: begin
						if (elapsed_inc > {2'b00, cmd_timeout_q}) begin
							abort_d   = 1'b1;
							retries_d = retries_inc;
							if (fail_err) begin
								status_d = ST_ERROR;
								phase_d  = PH_ERROR;
							end else begin
								phase_d = PH_CONFIG;
							end
						end
					end
					PH_START: begin
						if (elapsed_inc > {2'b00, boot_delay_q}) begin
							rearm_d         = 1'b1;
							scan_ctrl.clear = 1'b1;
							elapsed_d       = '0;
							phase_d         = PH_WAIT_CMD;
						end
					end
					PH_WAIT_CMD: begin
						if (elapsed_inc > conn_timeout_q) begin
							abort_d = 1'b1;
							phase_d = PH_STOP;
						end
					end
					PH_STREAM: begin
						if (elapsed_inc > idle_timeout_q) begin
							abort_d = 1'b1;
							phase_d = PH_STOP;
						end
					end
					PH_WAIT_ACK: begin
						if (elapsed_inc > idle_timeout_q) begin
							phase_d = PH_STOP;
						end
					end
					PH_STOP: begin
						phase_d  = PH_IDLE;
						status_d = ST_READY;
					end
					default: begin
					end
				endcase
			end
			REQ_BYTE: begin
				if (listening) begin
					scan_ctrl.shift = 1'b1;
					// Judge the message on its closing byte
					if (req.rx_last) begin
						scan_ctrl.clear = 1'b1;
						if (phase_q == PH_CFG_WAIT) begin
							if (scan_flags.ans) begin
								step_d    = step_q + 1'b1;
								retries_d = '0;
								phase_d   = PH_CONFIG;
							end else if (scan_flags.err) begin
								retries_d = retries_inc;
								if (fail_err) begin
									status_d = ST_ERROR;
									phase_d  = PH_ERROR;
								end else begin
									phase_d = PH_CONFIG;
								end
							end else begin
								rearm_d = 1'b1;
							end
						end else if (phase_q == PH_WAIT_CMD) begin
							if (scan_flags.ask) begin
								elapsed_d = '0;
								status_d  = ST_STREAMING;
								phase_d   = PH_STREAM;
							end else begin
								rearm_d = 1'b1;
							end
						end else begin
							if (scan_flags.quit) begin
								phase_d = PH_STOP;
							end else begin
								rearm_d = 1'b1;
							end
						end
					end
				end
			end
			REQ_CONFIG: begin
				cmd_d           = CMD_ACCEPT;
				phase_d         = PH_CONFIG;
				status_d        = ST_CONFIGURING;
				elapsed_d       = '0;
				step_d          = '0;
				retries_d       = '0;
				scan_ctrl.clear = 1'b1;
			end
			REQ_START: begin
				if (phase_q != PH_IDLE) begin
					cmd_d = CMD_BUSY;
				end else begin
					cmd_d     = CMD_ACCEPT;
					elapsed_d = '0;
					phase_d   = PH_START;
				end
			end
			REQ_END: begin
				cmd_d           = CMD_ACCEPT;
				rearm_d         = 1'b1;
				scan_ctrl.clear = 1'b1;
				elapsed_d       = '0;
				phase_d         = PH_WAIT_ACK;
			end
			default: begin
			end
		endcase

		// Drop scan updates for items that are not taken
		if (!accept) begin
			scan_ctrl = '0;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_delay_q   <= BOOT_DELAY_RST;
			cmd_timeout_q  <= CMD_TIMEOUT_RST;
			conn_timeout_q <= CONN_TIMEOUT_RST;
			idle_timeout_q <= IDLE_TIMEOUT_RST;
			retry_limit_q  <= RETRY_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_BOOT_DELAY:   boot_delay_q   <= cfg.data[SHORT_W-1:0];
				CFG_CMD_TIMEOUT:  cmd_timeout_q  <= cfg.data[SHORT_W-1:0];
				CFG_CONN_TIMEOUT: conn_timeout_q <= cfg.data[LONG_W-1:0];
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg.data[LONG_W-1:0];
				CFG_RETRY_LIMIT:  retry_limit_q  <= cfg.data[RETRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance the sequencer state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			step_q    <= '0;
			retries_q <= '0;
			status_q  <= ST_READY;
		end else if (accept) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			step_q    <= step_d;
			retries_q <= retries_d;
			status_q  <= status_d;
		end
	end

	// Hold the result until res takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req.ready) begin
			res_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= cmd_d;
			status_res_q <= status_d;
			phase_res_q  <= phase_d;
			send_q       <= send_d;
			abort_q      <= abort_d;
			rearm_q      <= rearm_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.cmd_result  = cmd_q;
	assign res.link_status = status_res_q;
	assign res.phase_now   = phase_res_q;
	assign res.send_step   = send_q;
	assign res.abort_rx    = abort_q;
	assign res.rearm_rx    = rearm_q;

	// A step is issued only on entry to the reply wait
	a_send_in_cfg_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (send_q != '0) |-> phase_res_q == PH_CFG_WAIT)
		else $error("send_step without entry to config_wait");

	// The error phase always reports the error status
	a_error_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> status_q == ST_ERROR)
		else $error("error phase with status other than error");

	// Streaming phase always reports streaming status
	a_stream_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STREAM |-> status_q == ST_STREAMING)
		else $error("stream phase with status other than streaming");

	// Never abort and rearm the receiver in one result
	a_abort_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(abort_q && rearm_q))
		else $error("abort_rx and rearm_rx both set");

	// Every accepted item leaves a result in the output register
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted item produced no result");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rmss_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE, PH_CONFIG, PH_CFG_WAIT, PH_START, PH_WAIT_CMD,
		PH_STREAM, PH_WAIT_ACK, PH_STOP, PH_ERROR
	} seq_phase_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_last;
	} radio_item_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd_result;
		logic [STATUS_W-1:0] link_status;
		logic [PHASE_W-1:0]  phase_now;
		logic [STEP_W-1:0]   send_step;
		logic                abort_rx;
		logic                rearm_rx;
	} link_report_t;

	// request code outside the defined set
	localparam logic [REQ_W-1:0] REQ_SPARE = 3'd5;

	// answer expected for each step, step one in the lowest slot
	localparam logic [2:0][23:0] STEP_ANSWER = {24'h454E44, 24'h414F4B, 24'h434D44};

	localparam int TOP_RANGE_TICKS = 40;
	localparam int HOLD_OFF_AT     = 300;
	localparam int HOLD_OFF_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rmss_req_if req_ch();
	rmss_res_if res_ch();
	rmss_cfg_if cfg_ch();

	radio_module_session_sequencer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// sequencer state as predicted
	seq_phase_t          phase_q   = PH_IDLE;
	logic [LONG_W-1:0]   elapsed_q = '0;
	logic [STEP_W-1:0]   step_q    = '0;
	logic [RETRY_W-1:0]  retries_q = '0;
	logic [STATUS_W-1:0] status_q  = ST_READY;
	logic [15:0]         history_q = '0;
	scan_flags_t         found_q   = '0;

	// register contents as written
	logic [SHORT_W-1:0] boot_delay_q      = BOOT_DELAY_RST;
	logic [SHORT_W-1:0] command_timeout_q = CMD_TIMEOUT_RST;
	logic [LONG_W-1:0]  connect_timeout_q = CONN_TIMEOUT_RST;
	logic [LONG_W-1:0]  idle_timeout_q    = IDLE_TIMEOUT_RST;
	logic [RETRY_W-1:0] retry_limit_q     = RETRY_LIMIT_RST;

	radio_item_t  radio_items_todo[$];
	link_report_t link_reports_due[$];
	int mismatch_count = 0;
	int reports_seen = 0;
	int hold_left = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 63;

	always #1 clk = ~clk;

	// count a failed attempt; give up once the budget is spent
	function automatic void count_retry();
		if (retries_q != RETRY_MAX) retries_q++;
		if (retries_q >= retry_limit_q) begin
			status_q = ST_ERROR;
			phase_q = PH_ERROR;
		end else begin
			phase_q = PH_CONFIG;
		end
	endfunction

	function automatic link_report_t predict_link(input radio_item_t it);
		link_report_t r;
		logic [23:0] word;
		scan_flags_t f;
		r = '0;
		case (it.req_type)
			REQ_TICK: begin
				if (elapsed_q != ELAPSED_MAX) elapsed_q++;
				case (phase_q)
					PH_CONFIG: begin
						if (elapsed_q > boot_delay_q) begin
							if (step_q < NUM_STEPS) begin
								r.send_step = step_q + 1'b1;
								r.rearm_rx = 1'b1;
								history_q = '0;
								found_q = '0;
								elapsed_q = '0;
								phase_q = PH_CFG_WAIT;
							end else begin
								status_q = ST_READY;
								phase_q = PH_IDLE;
							end
						end
					end
					PH_CFG_WAIT: begin
						if (elapsed_q > command_timeout_q) begin
							r.abort_rx = 1'b1;
							count_retry();
						end
					end
					PH_START: begin
						if (elapsed_q > boot_delay_q) begin
							r.rearm_rx = 1'b1;
							history_q = '0;
							found_q = '0;
							elapsed_q = '0;
							phase_q = PH_WAIT_CMD;
						end
					end
					PH_WAIT_CMD: begin
						if (elapsed_q > connect_timeout_q) begin
							r.abort_rx = 1'b1;
							phase_q = PH_STOP;
						end
					end
					PH_STREAM: begin
						if (elapsed_q > idle_timeout_q) begin
							r.abort_rx = 1'b1;
							phase_q = PH_STOP;
						end
					end
					// quit timeout leaves without aborting the receiver
					PH_WAIT_ACK: begin
						if (elapsed_q > idle_timeout_q) phase_q = PH_STOP;
					end
					PH_STOP: begin
						phase_q = PH_IDLE;
						status_q = ST_READY;
					end
					default: ;
				endcase
			end
			REQ_BYTE: begin
				// scan only while listening
				if (phase_q == PH_CFG_WAIT || phase_q == PH_WAIT_CMD
						|| phase_q == PH_WAIT_ACK) begin
					word = {history_q, it.rx_byte};
					if (step_q < NUM_STEPS && word == STEP_ANSWER[step_q]) found_q.ans = 1'b1;
					if (word == ERR_WORD) found_q.err = 1'b1;
					if (it.rx_byte == ASK_BYTE) found_q.ask = 1'b1;
					if (it.rx_byte == QUIT_BYTE) found_q.quit = 1'b1;
					history_q = word[15:0];
					// judge the closed message and drop the scan state
					if (it.rx_last) begin
						f = found_q;
						history_q = '0;
						found_q = '0;
						case (phase_q)
							PH_CFG_WAIT: begin
								if (f.ans) begin
									step_q++;
									retries_q = '0;
									phase_q = PH_CONFIG;
								end else if (f.err) begin
									count_retry();
								end else begin
									r.rearm_rx = 1'b1;
								end
							end
							PH_WAIT_CMD: begin
								if (f.ask) begin
									elapsed_q = '0;
									status_q = ST_STREAMING;
									phase_q = PH_STREAM;
								end else begin
									r.rearm_rx = 1'b1;
								end
							end
							default: begin
								if (f.quit) phase_q = PH_STOP;
								else r.rearm_rx = 1'b1;
							end
						endcase
					end
				end
			end
			REQ_CONFIG: begin
				r.cmd_result = CMD_ACCEPT;
				phase_q = PH_CONFIG;
				status_q = ST_CONFIGURING;
				elapsed_q = '0;
				step_q = '0;
				retries_q = '0;
				history_q = '0;
				found_q = '0;
			end
			REQ_START: begin
				if (phase_q != PH_IDLE) begin
					r.cmd_result = CMD_BUSY;
				end else begin
					r.cmd_result = CMD_ACCEPT;
					elapsed_q = '0;
					phase_q = PH_START;
				end
			end
			REQ_END: begin
				r.cmd_result = CMD_ACCEPT;
				r.rearm_rx = 1'b1;
				history_q = '0;
				found_q = '0;
				elapsed_q = '0;
				phase_q = PH_WAIT_ACK;
			end
			default: ;
		endcase
		r.link_status = status_q;
		r.phase_now = phase_q;
		return r;
	endfunction

	task automatic add_item(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] b,
			input logic last);
		radio_item_t it;
		it.req_type = kind;
		it.rx_byte = b;
		it.rx_last = last;
		radio_items_todo.push_back(it);
	endtask

	// payload fields of a non-byte request carry junk
	task automatic add_request(input logic [REQ_W-1:0] kind);
		add_item(kind, $urandom_range(255), $urandom_range(1));
	endtask

	task automatic add_ticks(input int n);
		repeat (n) add_request(REQ_TICK);
	endtask

	task automatic add_noise(input int n);
		repeat (n) add_item($urandom_range(7), $urandom_range(255), $urandom_range(1));
	endtask

	// message of len bytes taken from the low end of word, after some junk
	task automatic add_reply(input logic [23:0] word, input int len);
		int junk;
		junk = $urandom_range(2);
		repeat (junk) add_item(REQ_BYTE, $urandom_range(255), 1'b0);
		for (int i = len - 1; i >= 0; i--) add_item(REQ_BYTE, word[8*i +: 8], i == 0);
	endtask

	task automatic add_noise_reply();
		int n;
		n = $urandom_range(1, 4);
		for (int i = n; i > 0; i--) add_item(REQ_BYTE, $urandom_range(255), i == 1);
	endtask

	// configure sequence answered in order, with failures mixed in at fail_pct percent
	task automatic gen_config_run(input int fail_pct);
		int done_steps;
		int tries;
		add_request(REQ_CONFIG);
		done_steps = 0;
		tries = 0;
		while (done_steps < NUM_STEPS && tries < 20) begin
			add_ticks(boot_delay_q + 1);
			if ($urandom_range(99) >= fail_pct) begin
				add_reply(STEP_ANSWER[done_steps], 3);
				done_steps++;
			end else begin
				case ($urandom_range(3))
					0: add_reply(ERR_WORD, 3);
					1: add_noise_reply();
					2: add_ticks(command_timeout_q + 1);
					default: add_reply(STEP_ANSWER[(done_steps + 1) % NUM_STEPS], 3);
				endcase
			end
			tries++;
		end
		if (done_steps == NUM_STEPS) add_ticks(boot_delay_q + 1);
	endtask

	// start, request, stream, end and quit, with timeouts now and then
	task automatic gen_stream_run();
		add_request(REQ_START);
		add_ticks(boot_delay_q + 1);
		if ($urandom_range(3) == 0) add_noise_reply();
		if ($urandom_range(5) == 0) begin
			add_ticks(connect_timeout_q + 2);
			return;
		end
		add_reply(ASK_BYTE, 1);
		add_ticks($urandom_range(idle_timeout_q));
		if ($urandom_range(3) == 0) add_noise(2);
		if ($urandom_range(5) == 0) begin
			add_ticks(idle_timeout_q + 2);
			return;
		end
		add_request(REQ_END);
		if ($urandom_range(3) == 0) add_noise_reply();
		if ($urandom_range(4) == 0) add_ticks(idle_timeout_q + 1);
		else add_reply(QUIT_BYTE, 1);
		add_ticks(1);
	endtask

	task automatic gen_traffic(input int n);
		int first;
		first = radio_items_todo.size();
		while (radio_items_todo.size() - first < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: gen_config_run($urandom_range(3) == 0 ? 90 : 25);
				4, 5, 6: gen_stream_run();
				default: add_noise($urandom_range(1, 6));
			endcase
		end
	endtask

	// hold until every item is taken and every result checked
	task automatic wait_quiet();
		while (radio_items_todo.size() != 0 || req_ch.valid || link_reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [SHORT_W-1:0] boot, input logic [SHORT_W-1:0] cmd_to,
			input logic [LONG_W-1:0] conn, input logic [LONG_W-1:0] idle,
			input logic [RETRY_W-1:0] limit);
		logic [CFG_IDX_W-1:0] idxs [5];
		logic [CFG_DAT_W-1:0] vals [5];
		idxs = '{CFG_BOOT_DELAY, CFG_CMD_TIMEOUT, CFG_CONN_TIMEOUT, CFG_IDLE_TIMEOUT,
			CFG_RETRY_LIMIT};
		vals = '{boot, cmd_to, conn, idle, limit};
		for (int i = 0; i < 5; i++) begin
			cfg_ch.index <= idxs[i];
			cfg_ch.data <= vals[i];
			cfg_ch.valid <= 1'b1;
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		boot_delay_q = boot;
		command_timeout_q = cmd_to;
		connect_timeout_q = conn;
		idle_timeout_q = idle;
		retry_limit_q = limit;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// offer items from the queue; predict each one as it transfers
	always @(posedge clk) begin : item_driver
		radio_item_t taken;
		radio_item_t nxt;
		logic offer;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				taken = {req_ch.req_type, req_ch.rx_byte, req_ch.rx_last};
				link_reports_due.push_back(predict_link(taken));
			end
			if (!req_ch.valid || req_ch.ready) begin
				offer = radio_items_todo.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (offer) begin
					nxt = radio_items_todo.pop_front();
					req_ch.req_type <= nxt.req_type;
					req_ch.rx_byte <= nxt.rx_byte;
					req_ch.rx_last <= nxt.rx_last;
				end
				req_ch.valid <= offer;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : report_monitor
		link_report_t got;
		link_report_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.cmd_result, res_ch.link_status, res_ch.phase_now,
					res_ch.send_step, res_ch.abort_rx, res_ch.rearm_rx};
				if (link_reports_due.size() == 0) begin
					$error("result transfer with no item pending: phase_now %0d", got.phase_now);
					mismatch_count++;
				end else begin
					want = link_reports_due.pop_front();
					check_field("cmd_result", want.cmd_result, got.cmd_result);
					check_field("link_status", want.link_status, got.link_status);
					check_field("phase_now", want.phase_now, got.phase_now);
					check_field("send_step", want.send_step, got.send_step);
					check_field("abort_rx", want.abort_rx, got.abort_rx);
					check_field("rearm_rx", want.rearm_rx, got.rearm_rx);
				end
				reports_seen++;
				// hold off once for a long stretch so the input backs up
				if (reports_seen == HOLD_OFF_AT) hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.rx_byte = '0;
		req_ch.rx_last = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BOOT_DELAY;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: ignored bytes, spare code, busy start, end and quit
		add_item(REQ_BYTE, ASK_BYTE, 1'b1);
		add_request(REQ_SPARE);
		add_request(REQ_START);
		add_request(REQ_START);
		add_item(REQ_BYTE, QUIT_BYTE, 1'b1);
		add_request(REQ_END);
		add_reply(QUIT_BYTE, 1);
		add_ticks(1);
		wait_quiet();

		// zero timing, first failure is fatal; leave error by end stream
		load_settings('0, '0, '0, '0, 4'd1);
		add_request(REQ_CONFIG);
		add_ticks(2);
		add_request(REQ_END);
		add_ticks(2);
		gen_traffic(150);
		wait_quiet();

		// mid-range timing; answer split across messages, then an error reply
		send_idle_pct = 63;
		recv_idle_pct = 30;
		load_settings(16'd3, 16'd8, 18'd20, 18'd30, 4'd3);
		add_request(REQ_CONFIG);
		add_ticks(4);
		add_item(REQ_BYTE, STEP_ANSWER[0][23:16], 1'b0);
		add_item(REQ_BYTE, STEP_ANSWER[0][15:8], 1'b1);
		add_item(REQ_BYTE, STEP_ANSWER[0][7:0], 1'b1);
		add_reply(ERR_WORD, 3);
		gen_traffic(450);
		wait_quiet();

		// top of every range; the quit timeout stays far off during the wait
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_settings(16'hFFFF, 16'hFFFF, ELAPSED_MAX, ELAPSED_MAX, RETRY_MAX);
		add_request(REQ_END);
		add_ticks(TOP_RANGE_TICKS);
		add_reply(QUIT_BYTE, 1);
		add_ticks(1);
		add_noise(50);
		wait_quiet();

		// short timing with the longest retry budget
		load_settings(16'd1, 16'd2, 18'd6, 18'd5, RETRY_MAX);
		gen_traffic(200);
		wait_quiet();

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
rtl/rmss_pkg.sv
rtl/rmss_req_if.sv
rtl/rmss_res_if.sv
rtl/rmss_cfg_if.sv
rtl/rmss_scan.sv
rtl/radio_module_session_sequencer.sv
dv/testbench.sv
